>>> design/scfe_pkg.sv
`default_nettype none

package scfe_pkg;

  // Frame numbers are five bits wide, so at most 32 frames can be resident.
  localparam int FRAME_W     = 5;
  localparam int FRAME_SLOTS = 32;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_EVICT  = 2'd3
  } opcode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  // Update of the per-frame resident and accessed flags.
  typedef struct packed {
    logic               upd_res;
    logic               res_val;
    logic               upd_acc;
    logic               acc_val;
    logic [FRAME_W-1:0] frame;
  } bits_cmd_t;

endpackage

`default_nettype wire

>>> design/scfe_ram.sv
`default_nettype none

module scfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/scfe_frame_bits.sv
`default_nettype none

module scfe_frame_bits
  import scfe_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire bits_cmd_t              cmd_i,
  output logic      [FRAME_SLOTS-1:0] resident_o,
  output logic      [FRAME_SLOTS-1:0] accessed_o
);

  logic [FRAME_SLOTS-1:0] resident_q;
  logic [FRAME_SLOTS-1:0] accessed_q;

  // Per-frame flags, cleared together at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resident_q <= '0;
      accessed_q <= '0;
    end else begin
      if (cmd_i.upd_res) begin
        resident_q[cmd_i.frame] <= cmd_i.res_val;
      end
      if (cmd_i.upd_acc) begin
        accessed_q[cmd_i.frame] <= cmd_i.acc_val;
      end
    end
  end

  assign resident_o = resident_q;
  assign accessed_o = accessed_q;

endmodule

`default_nettype wire

>>> design/second_chance_frame_evictor.sv
// Insert, touch and every request that ends in an error: the result is registered
// and shows in the cycle after the request is taken; busy stays low, so such
// requests can follow in every cycle. Remove and evict sweep the list; an evict
// whose first pass finds no victim makes a second pass. The list sweeps one entry
// per cycle through the single read port of the order memory; busy is high meanwhile.
// Reset (asynchronous, active low) empties the list and clears all frame flags.
`default_nettype none

module second_chance_frame_evictor
  import scfe_pkg::*;
#(
  parameter int NUM_FRAMES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode_i,
  input  wire logic [FRAME_W-1:0] frame_index_i,
  output logic                    done_o,
  output logic      [FRAME_W-1:0] victim_index_o,
  output logic                    victim_valid_o,
  output logic      [1:0]         status_o
);

  localparam int CNT_W  = $clog2(NUM_FRAMES + 1);
  localparam int ADDR_W = $clog2(NUM_FRAMES);

  typedef enum logic {
    S_IDLE,
    S_SWEEP
  } state_e;

  state_e             state_q, state_d;
  logic               is_evict_q, is_evict_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   wr_q, wr_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  logic [FRAME_W-1:0] victim_q, victim_d;
  logic               done_q, done_d;
  logic [FRAME_W-1:0] vidx_q, vidx_d;
  logic               vval_q, vval_d;
  status_e            stat_q, stat_d;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [FRAME_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [FRAME_W-1:0] ram_rdata;

  bits_cmd_t              bits_cmd;
  logic [FRAME_SLOTS-1:0] resident;
  logic [FRAME_SLOTS-1:0] accessed;

  logic in_range;
  logic is_res;
  logic list_full;
  logic acc_hit;
  logic drop;

  // Order list, front at address zero.
  scfe_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (NUM_FRAMES)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Resident and accessed flags per frame.
  scfe_frame_bits u_bits (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (bits_cmd),
    .resident_o (resident),
    .accessed_o (accessed)
  );

  assign in_range  = int'(frame_index_i) < NUM_FRAMES;
  assign is_res    = resident[frame_index_i];
  assign list_full = (count_q == CNT_W'(NUM_FRAMES));
  assign acc_hit   = accessed[ram_rdata];

  // The sweep compacts the list in place: every kept entry is copied to the write
  // pointer and a dropped entry leaves a gap that later copies close.
  assign drop = is_evict_q ? (!found_q && !acc_hit) : (ram_rdata == frame_q);

  // Sequencer next state.
  always_comb begin
    state_d    = state_q;
    is_evict_d = is_evict_q;
    frame_d    = frame_q;
    count_d    = count_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    pend_d     = pend_q;
    found_d    = found_q;
    victim_d   = victim_q;
    done_d     = 1'b0;
    vidx_d     = vidx_q;
    vval_d     = vval_q;
    stat_d     = stat_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[ADDR_W-1:0];
    ram_wdata  = frame_index_i;
    ram_raddr  = rd_q[ADDR_W-1:0];
    bits_cmd   = '0;
    bits_cmd.frame = frame_index_i;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          frame_d = frame_index_i;
          vidx_d  = '0;
          vval_d  = 1'b0;
          stat_d  = STAT_OK;
          rd_d    = '0;
          wr_d    = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          priority if (opcode_i == OP_EVICT) begin
            if (count_q == '0) begin
              stat_d = STAT_EMPTY;
              done_d = 1'b1;
            end else begin
              is_evict_d = 1'b1;
              state_d    = S_SWEEP;
            end
          end else if (!in_range) begin
            stat_d = STAT_ABSENT;
            done_d = 1'b1;
          end else if (opcode_i == OP_INSERT) begin
            done_d = 1'b1;
            if (is_res || list_full) begin
              stat_d = STAT_FULL;
            end else begin
              ram_we           = 1'b1;
              count_d          = count_q + 1'b1;
              bits_cmd.upd_res = 1'b1;
              bits_cmd.res_val = 1'b1;
              bits_cmd.upd_acc = 1'b1;
              bits_cmd.acc_val = 1'b0;
            end
          end else if (!is_res) begin
            stat_d = STAT_ABSENT;
            done_d = 1'b1;
          end else if (opcode_i == OP_REMOVE) begin
            bits_cmd.upd_res = 1'b1;
            bits_cmd.res_val = 1'b0;
            bits_cmd.upd_acc = 1'b1;
            bits_cmd.acc_val = 1'b0;
            is_evict_d       = 1'b0;
            state_d          = S_SWEEP;
          end else begin
            bits_cmd.upd_acc = 1'b1;
            bits_cmd.acc_val = 1'b1;
            done_d           = 1'b1;
          end
        end
      end

      S_SWEEP: begin
        // Issue the next read; its data returns in the next cycle.
        if (rd_q < count_q) begin
          rd_d   = rd_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end

        if (pend_q) begin
          // An accessed frame ahead of the victim gets its second chance.
          if (is_evict_q && !found_q && acc_hit) begin
            bits_cmd.upd_acc = 1'b1;
            bits_cmd.acc_val = 1'b0;
            bits_cmd.frame   = ram_rdata;
          end
          if (drop) begin
            if (is_evict_q) begin
              found_d  = 1'b1;
              victim_d = ram_rdata;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = wr_q[ADDR_W-1:0];
            ram_wdata = ram_rdata;
            wr_d      = wr_q + 1'b1;
          end
        end else if (rd_q == count_q) begin
          // End of a pass.
          priority if (!is_evict_q) begin
            count_d = count_q - 1'b1;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = wr_q[ADDR_W-1:0];
            ram_wdata = victim_q;
            vidx_d    = victim_q;
            vval_d    = 1'b1;
            done_d    = 1'b1;
            state_d   = S_IDLE;
          end else begin
            // Every frame was accessed; the second pass takes the front one.
            rd_d   = '0;
            wr_d   = '0;
            pend_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      is_evict_q <= 1'b0;
      count_q    <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      is_evict_q <= is_evict_d;
      count_q    <= count_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      pend_q     <= pend_d;
      found_q    <= found_d;
      done_q     <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    frame_q  <= frame_d;
    victim_q <= victim_d;
    vidx_q   <= vidx_d;
    vval_q   <= vval_d;
    stat_q   <= stat_d;
  end

  assign busy           = (state_q == S_SWEEP);
  assign done_o         = done_q;
  assign victim_index_o = vidx_q;
  assign victim_valid_o = vval_q;
  assign status_o       = stat_q;

endmodule

`default_nettype wire

>>> design/scfe_checker.sv
`default_nettype none

module scfe_checker
  import scfe_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic [FRAME_W-1:0] victim_index_o,
  input wire logic               victim_valid_o,
  input wire logic [1:0]         status_o
);

  // A result follows either a request taken while idle or the end of a sweep.
  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start) || $past(busy)))
    else $error("result without a request");

  // A finished sweep always delivers its result.
  a_sweep_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("sweep ended without a result");

  // A victim comes with an ok status.
  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && victim_valid_o) |-> (status_o == STAT_OK))
    else $error("victim reported with an error status");

  // Without a victim the victim index reads zero.
  a_no_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !victim_valid_o) |-> (victim_index_o == '0))
    else $error("victim index set without a victim");

endmodule

bind second_chance_frame_evictor scfe_checker u_scfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .victim_index_o (victim_index_o),
  .victim_valid_o (victim_valid_o),
  .status_o       (status_o)
);

`default_nettype wire
